/* hdl/lnmp_pkg.sv */
// shared types, constants and helpers for the lucas number mod prime block
package lnmp_pkg;

    localparam int VAL_W = 30;

    typedef logic [VAL_W-1:0] val_t;

    // 2x2 matrix, index [row][col]
    typedef logic [1:0][1:0][VAL_W-1:0] mat_t;

    localparam val_t PRIME = 30'd1000000007;
    localparam logic [31:0] PRIME_X2 = 32'd2000000014;

    // floor(2^60 / PRIME) for the barrett quotient estimate
    localparam logic [30:0] BARRETT_MU = 31'd1152921496;

    localparam mat_t MAT_IDENTITY = {30'd1, 30'd0, 30'd0, 30'd1};
    localparam mat_t MAT_FIB      = {30'd0, 30'd1, 30'd1, 30'd1};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIT,
        ST_ISSUE,
        ST_WAIT,
        ST_COMMIT,
        ST_TRACE
    } ctl_state_t;

    typedef enum logic [2:0] {
        MM_IDLE,
        MM_MUL,
        MM_EST,
        MM_QP,
        MM_FIX
    } mm_state_t;

    typedef struct packed {
        logic start;
        val_t a;
        val_t b;
    } mm_req_t;

    typedef struct packed {
        logic done;
        val_t result;
    } mm_rsp_t;

    // (a + b) mod PRIME for operands already below PRIME
    function automatic val_t mod_add(input val_t a, input val_t b);
        logic [VAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, PRIME})
        begin
            s = s - {1'b0, PRIME};
        end
        return s[VAL_W-1:0];
    endfunction

endpackage

/* hdl/lucas_number_mod_prime.sv */
// top level: lucas number mod prime by fibonacci matrix powering on a shared multiply-reduce unit
// one accumulator product per set exponent bit, one squaring per bit below the highest set bit
// each matrix product is 8 modular products on the one multiply-reduce unit
// one transaction at a time; the result register lets the next one start early
// reset: asynchronous, active low, clears the sequencer and valid flags; no clearing pass
module lucas_number_mod_prime #(
    parameter int EXPONENT_WIDTH = 31
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  logic [EXPONENT_WIDTH-1:0] exponent,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output logic [29:0]               lucas_value
);

    // sequencer state
    lnmp_pkg::ctl_state_t state_reg;
    lnmp_pkg::ctl_state_t state_next;

    // remaining exponent bits, shifted down one per squaring
    logic [EXPONENT_WIDTH-1:0] exp_reg;
    logic [EXPONENT_WIDTH-1:0] exp_next;

    // accumulator, running base and the matrix being built
    lnmp_pkg::mat_t acc_reg;
    lnmp_pkg::mat_t acc_next;
    lnmp_pkg::mat_t base_reg;
    lnmp_pkg::mat_t base_next;
    lnmp_pkg::mat_t tmp_reg;
    lnmp_pkg::mat_t tmp_next;

    // first of the two products of an entry
    lnmp_pkg::val_t part_reg;
    lnmp_pkg::val_t part_next;

    // product index: row, col, inner term
    logic [2:0] prod_idx_reg;
    logic [2:0] prod_idx_next;

    // set while squaring the base, clear while multiplying into the accumulator
    logic sq_reg;
    logic sq_next;

    logic           out_valid_reg;
    logic           out_valid_next;
    lnmp_pkg::val_t out_value_reg;
    lnmp_pkg::val_t out_value_next;

    lnmp_pkg::mm_req_t mm_req;
    lnmp_pkg::mm_rsp_t mm_rsp;

    lnmp_pkg::mat_t left_mat;
    logic           row_i;
    logic           col_j;
    logic           term_k;
    logic           out_free;

    assign row_i  = prod_idx_reg[2];
    assign col_j  = prod_idx_reg[1];
    assign term_k = prod_idx_reg[0];

    // squaring uses the base on both sides
    assign left_mat = sq_reg ? base_reg : acc_reg;

    // output slot is free when empty or being taken this cycle
    assign out_free = !out_valid_reg || !rsp_stall;

    lnmp_mulmod u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mm_req),
        .rsp   (mm_rsp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lnmp_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = lnmp_pkg::ST_BIT;
                end
            end
            lnmp_pkg::ST_BIT:
            begin
                state_next = (exp_reg == '0) ? lnmp_pkg::ST_TRACE : lnmp_pkg::ST_ISSUE;
            end
            lnmp_pkg::ST_ISSUE:
            begin
                state_next = lnmp_pkg::ST_WAIT;
            end
            lnmp_pkg::ST_WAIT:
            begin
                if (mm_rsp.done)
                begin
                    state_next = (prod_idx_reg == 3'd7) ? lnmp_pkg::ST_COMMIT
                                                        : lnmp_pkg::ST_ISSUE;
                end
            end
            lnmp_pkg::ST_COMMIT:
            begin
                state_next = lnmp_pkg::ST_BIT;
            end
            lnmp_pkg::ST_TRACE:
            begin
                if (out_free)
                begin
                    state_next = lnmp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lnmp_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and unit requests
    always_comb
    begin
        exp_next       = exp_reg;
        acc_next       = acc_reg;
        base_next      = base_reg;
        tmp_next       = tmp_reg;
        part_next      = part_reg;
        prod_idx_next  = prod_idx_reg;
        sq_next        = sq_reg;
        out_value_next = out_value_reg;
        out_valid_next = out_valid_reg && rsp_stall;

        mm_req.start = 1'b0;
        mm_req.a     = left_mat[row_i][term_k];
        mm_req.b     = base_reg[term_k][col_j];

        case (state_reg)
            lnmp_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    exp_next      = exponent;
                    acc_next      = lnmp_pkg::MAT_IDENTITY;
                    base_next     = lnmp_pkg::MAT_FIB;
                    prod_idx_next = 3'd0;
                end
            end
            lnmp_pkg::ST_BIT:
            begin
                // low bit set: fold the base in first, square afterwards
                sq_next = !exp_reg[0];
            end
            lnmp_pkg::ST_ISSUE:
            begin
                mm_req.start = 1'b1;
            end
            lnmp_pkg::ST_WAIT:
            begin
                if (mm_rsp.done)
                begin
                    if (!term_k)
                    begin
                        part_next = mm_rsp.result;
                    end
                    else
                    begin
                        tmp_next[row_i][col_j] = lnmp_pkg::mod_add(part_reg, mm_rsp.result);
                    end
                    prod_idx_next = prod_idx_reg + 3'd1;
                end
            end
            lnmp_pkg::ST_COMMIT:
            begin
                prod_idx_next = 3'd0;
                if (sq_reg)
                begin
                    base_next = tmp_reg;
                    exp_next  = exp_reg >> 1;
                end
                else
                begin
                    acc_next   = tmp_reg;
                    exp_next[0] = 1'b0;
                end
            end
            lnmp_pkg::ST_TRACE:
            begin
                if (out_free)
                begin
                    out_value_next = lnmp_pkg::mod_add(acc_reg[0][0], acc_reg[1][1]);
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                prod_idx_next = 3'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lnmp_pkg::ST_IDLE;
            prod_idx_reg  <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prod_idx_reg  <= prod_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        exp_reg       <= exp_next;
        acc_reg       <= acc_next;
        base_reg      <= base_next;
        tmp_reg       <= tmp_next;
        part_reg      <= part_next;
        sq_reg        <= sq_next;
        out_value_reg <= out_value_next;
    end

    // a new transaction is taken only while the sequencer is idle
    assign req_stall   = (state_reg != lnmp_pkg::ST_IDLE);
    assign rsp_valid   = out_valid_reg;
    assign lucas_value = out_value_reg;

    // a result appears only out of the trace step
    a_rise_from_trace: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == lnmp_pkg::ST_TRACE))
        else $error("result valid rose outside the trace step");

    // the result is always fully reduced
    a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (lucas_value < lnmp_pkg::PRIME))
        else $error("result not reduced below the prime");

    // the multiply-reduce unit answers only while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mm_rsp.done |-> (state_reg == lnmp_pkg::ST_WAIT))
        else $error("multiply-reduce done outside the wait step");

    // every matrix product starts at its first term
    a_idx_at_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lnmp_pkg::ST_BIT) |-> (prod_idx_reg == 3'd0))
        else $error("product index not cleared at bit step");

endmodule

/* hdl/lnmp_mulmod.sv */
// shared multiply-reduce unit: (a * b) mod prime by barrett reduction on one multiplier
module lnmp_mulmod (
    input  logic              clk,
    input  logic              rst_n,
    input  lnmp_pkg::mm_req_t req,
    output lnmp_pkg::mm_rsp_t rsp
);

    lnmp_pkg::mm_state_t state_reg;
    lnmp_pkg::mm_state_t state_next;

    lnmp_pkg::val_t op_a_reg;
    lnmp_pkg::val_t op_b_reg;
    logic [59:0]    x_reg;
    logic [61:0]    prod_reg;
    lnmp_pkg::val_t result_reg;
    lnmp_pkg::val_t result_next;
    logic           done_reg;
    logic           done_next;

    logic [30:0] mult_x;
    logic [30:0] mult_y;
    logic [61:0] product;

    logic [31:0] diff;
    logic [32:0] diff_m1;
    logic [32:0] diff_m2;

    // the one multiplier, operands picked by step
    always_comb
    begin
        case (state_reg)
            lnmp_pkg::MM_EST:
            begin
                mult_x = x_reg[59:29];
                mult_y = lnmp_pkg::BARRETT_MU;
            end
            lnmp_pkg::MM_QP:
            begin
                mult_x = prod_reg[61:31];
                mult_y = {1'b0, lnmp_pkg::PRIME};
            end
            default:
            begin
                mult_x = {1'b0, op_a_reg};
                mult_y = {1'b0, op_b_reg};
            end
        endcase
    end

    assign product = mult_x * mult_y;

    // remainder is below three times the prime, so 32 bits carry it
    assign diff    = x_reg[31:0] - prod_reg[31:0];
    assign diff_m1 = {1'b0, diff} - {3'b000, lnmp_pkg::PRIME};
    assign diff_m2 = {1'b0, diff} - {1'b0, lnmp_pkg::PRIME_X2};

    always_comb
    begin
        case (state_reg)
            lnmp_pkg::MM_IDLE: state_next = req.start ? lnmp_pkg::MM_MUL : lnmp_pkg::MM_IDLE;
            lnmp_pkg::MM_MUL:  state_next = lnmp_pkg::MM_EST;
            lnmp_pkg::MM_EST:  state_next = lnmp_pkg::MM_QP;
            lnmp_pkg::MM_QP:   state_next = lnmp_pkg::MM_FIX;
            lnmp_pkg::MM_FIX:  state_next = lnmp_pkg::MM_IDLE;
            default:           state_next = lnmp_pkg::MM_IDLE;
        endcase
    end

    always_comb
    begin
        done_next   = 1'b0;
        result_next = result_reg;
        if (state_reg == lnmp_pkg::MM_FIX)
        begin
            done_next = 1'b1;
            if (!diff_m2[32])
            begin
                result_next = diff_m2[29:0];
            end
            else if (!diff_m1[32])
            begin
                result_next = diff_m1[29:0];
            end
            else
            begin
                result_next = diff[29:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lnmp_pkg::MM_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == lnmp_pkg::MM_IDLE && req.start)
        begin
            op_a_reg <= req.a;
            op_b_reg <= req.b;
        end
        if (state_reg == lnmp_pkg::MM_MUL)
        begin
            x_reg <= product[59:0];
        end
        if (state_reg == lnmp_pkg::MM_EST || state_reg == lnmp_pkg::MM_QP)
        begin
            prod_reg <= product;
        end
        result_reg <= result_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule

/* tb/lucas_checker.sv */
// checker for the lucas number mod prime block: predicts each result and compares it
module lucas_checker #(
    parameter int EXPONENT_WIDTH = 31
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    input  logic                      req_stall,
    input  logic [EXPONENT_WIDTH-1:0] exponent,
    input  logic                      rsp_valid,
    input  logic                      rsp_stall,
    input  logic [29:0]               lucas_value,
    output int                        error_count,
    output int                        outstanding
);

    typedef longint unsigned u64_t;

    localparam u64_t MODULUS = 64'd1000000007;
    localparam int   REPORT_MAX = 10;

    typedef struct {
        logic [EXPONENT_WIDTH-1:0] n;
        lnmp_pkg::val_t            lucas;
    } lucas_expect_t;

    lucas_expect_t expected_lucas[$];
    int            errors;
    int            reported;

    // 2x2 product with every sum of products reduced mod p
    function automatic lnmp_pkg::mat_t mat_mul_mod(input lnmp_pkg::mat_t x,
                                                   input lnmp_pkg::mat_t y);
        lnmp_pkg::mat_t r;
        u64_t s;
        u64_t p;
        for (int i = 0; i < 2; i++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                s = 64'd0;
                for (int k = 0; k < 2; k++)
                begin
                    p = {34'd0, x[i][k]} * {34'd0, y[k][j]};
                    s = (s + (p % MODULUS)) % MODULUS;
                end
                r[i][j] = s[29:0];
            end
        end
        return r;
    endfunction

    // trace of the fibonacci matrix raised to n, mod p
    function automatic lnmp_pkg::val_t lucas_trace_mod(input logic [EXPONENT_WIDTH-1:0] n);
        lnmp_pkg::mat_t acc;
        lnmp_pkg::mat_t base;
        u64_t tr;
        acc[0][0] = 30'd1;
        acc[0][1] = 30'd0;
        acc[1][0] = 30'd0;
        acc[1][1] = 30'd1;
        base[0][0] = 30'd1;
        base[0][1] = 30'd1;
        base[1][0] = 30'd1;
        base[1][1] = 30'd0;
        for (int b = 0; b < EXPONENT_WIDTH; b++)
        begin
            if (n[b])
            begin
                acc = mat_mul_mod(acc, base);
            end
            base = mat_mul_mod(base, base);
        end
        tr = ({34'd0, acc[0][0]} + {34'd0, acc[1][1]}) % MODULUS;
        return tr[29:0];
    endfunction

    always @(posedge clk)
    begin
        lucas_expect_t e;
        if (rst_n)
        begin
            // older transaction leaves before a new one enters
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_lucas.size() == 0)
                begin
                    errors++;
                    if (reported < REPORT_MAX)
                    begin
                        reported++;
                        $display("mismatch: unexpected result %0d", lucas_value);
                    end
                end
                else
                begin
                    e = expected_lucas.pop_front();
                    if (lucas_value !== e.lucas)
                    begin
                        errors++;
                        if (reported < REPORT_MAX)
                        begin
                            reported++;
                            $display("mismatch: exponent %0d lucas_value expected %0d got %0d",
                                     e.n, e.lucas, lucas_value);
                        end
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                e.n = exponent;
                e.lucas = lucas_trace_mod(exponent);
                expected_lucas.insert(expected_lucas.size(), e);
            end
        end
        error_count <= errors;
        outstanding <= expected_lucas.size();
    end

endmodule

/* tb/tb.sv */
// testbench top for the lucas number mod prime block: stimulus, idling and verdict
module tb;

    localparam int EXP_W = 31;
    // tail is sized to the longest per-transaction run, that of an all-ones exponent
    localparam int TAIL_CYCLES = 3200;
    // watchdog limit, several times the slowest correct run over every transaction and its stalls
    localparam int CYCLE_LIMIT = 15000000;
    localparam int RANDOM_PER_PHASE = 384;

    logic             clk;
    logic             rst_n;
    logic             req_valid;
    logic             req_stall;
    logic [EXP_W-1:0] exponent;
    logic             rsp_valid;
    logic             rsp_stall;
    logic [29:0]      lucas_value;

    int error_count;
    int outstanding;
    int cycle_count;

    // idle rates in percent, changed per phase
    int send_idle_pct;
    int recv_idle_pct;

    // free-running clock, period 12
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    lucas_number_mod_prime #(
        .EXPONENT_WIDTH(EXP_W)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .exponent   (exponent),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .lucas_value(lucas_value)
    );

    lucas_checker #(
        .EXPONENT_WIDTH(EXP_W)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .exponent   (exponent),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .lucas_value(lucas_value),
        .error_count(error_count),
        .outstanding(outstanding)
    );

    // receiver side: quiet in reset, then stall at random, one update per edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // present one exponent and hold it until the block takes it
    // valid stays high on return so back-to-back transactions need no second assignment
    task automatic send_exponent(input logic [EXP_W-1:0] n);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            // idle cycle, payload is free to wander while valid is low
            req_valid <= 1'b0;
            exponent <= EXP_W'($urandom);
            @(posedge clk);
        end
        req_valid <= 1'b1;
        exponent <= n;
        @(posedge clk);
        // acceptance is judged on the stall seen at that edge
        while (req_stall)
        begin
            @(posedge clk);
        end
    endtask

    // drop valid and hold off until every expected result is back
    task automatic drain_results();
        req_valid <= 1'b0;
        // let the checker register the last accepted transaction before the count is read
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    // random exponent, mostly short bit lengths so the run stays fast
    function automatic logic [EXP_W-1:0] pick_exponent();
        int sel;
        int w;
        logic [31:0] raw;
        sel = $urandom_range(0, 99);
        raw = $urandom;
        if (sel < 10)
        begin
            // full width, reaches every exponent bit
            return raw[EXP_W-1:0];
        end
        if (sel < 30)
        begin
            w = $urandom_range(11, 20);
        end
        else
        begin
            w = $urandom_range(0, 10);
        end
        raw = raw & ((32'd1 << w) - 32'd1);
        return raw[EXP_W-1:0];
    endfunction

    // run one idling phase of random transactions and drain at its end
    task automatic random_phase(input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < RANDOM_PER_PHASE; i++)
        begin
            send_exponent(pick_exponent());
        end
        // sender pauses here until the block has nothing left in flight
        drain_results();
    endtask

    // watchdog: a hung block ends the run here
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        // every input known from time zero
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        exponent <= '0;
        // directed transactions run under the first idling mix
        send_idle_pct = 16;
        recv_idle_pct = 61;

        repeat (7)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero and one, small values, all-ones and single-bit edges,
        // alternating patterns, values around the modulus
        send_exponent(31'd0);
        send_exponent(31'd1);
        send_exponent(31'd2);
        send_exponent(31'd3);
        send_exponent(31'd4);
        send_exponent(31'd5);
        send_exponent(31'd10);
        send_exponent(31'h7FFFFFFF);
        send_exponent(31'h40000000);
        send_exponent(31'h3FFFFFFF);
        send_exponent(31'h55555555);
        send_exponent(31'h2AAAAAAA);
        send_exponent(31'd1000000006);
        send_exponent(31'd1000000007);
        send_exponent(31'd2000000014);
        send_exponent(31'h00010000);
        send_exponent(31'h00000080);
        send_exponent(31'h7FFFFFFE);
        send_exponent(31'h7F00000F);
        send_exponent(31'd0);
        drain_results();

        // sender lightly idle, receiver heavily stalled
        random_phase(16, 61);
        // roles swapped
        random_phase(61, 16);
        // full rate on both sides
        random_phase(0, 0);

        // let the block settle after the last result
        repeat (TAIL_CYCLES)
        begin
            @(posedge clk);
        end

        if (error_count == 0 && outstanding == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
